### rtl/core/acfm_pkg.sv
// Shared types, constants and helpers for the channel fade manager.
package acfm_pkg;

	localparam int CH_W              = 6;
	localparam int NUM_CHANNELS_DEF  = 60;
	localparam int FIRST_MUSIC_DEF   = 2;
	localparam int FIRST_EFFECT_DEF  = 6;
	localparam int EVENT_CAP         = 60;

	localparam int DVD_W = 17;
	localparam int DVS_W = 10;

	// channel flag bits
	localparam int F_STREAMED = 0;
	localparam int F_MEMORY   = 1;
	localparam int F_FADE_OUT = 2;
	localparam int F_WAIT     = 3;
	localparam int F_FADE_IN  = 4;
	localparam int F_DESTROY  = 5;
	localparam int F_DONE     = 6;

	localparam logic [6:0] VOL_FULL   = 7'd127;
	localparam logic [6:0] PAN_CENTER = 7'd64;
	localparam logic [6:0] NO_SUCC    = 7'd127;
	localparam logic [9:0] MAG_MAX    = 10'd1023;

	localparam logic REG_SOUND_ENABLED = 1'b0;

	localparam logic [3:0] CMD_ALLOC       = 4'd0;
	localparam logic [3:0] CMD_PLAY_STREAM = 4'd1;
	localparam logic [3:0] CMD_PLAY_MEMORY = 4'd2;
	localparam logic [3:0] CMD_STOP        = 4'd3;
	localparam logic [3:0] CMD_SET_VOLUME  = 4'd4;
	localparam logic [3:0] CMD_SET_PAN     = 4'd5;
	localparam logic [3:0] CMD_PLAY_DONE   = 4'd6;
	localparam logic [3:0] CMD_DESTROY     = 4'd7;
	localparam logic [3:0] CMD_TICK        = 4'd8;
	localparam logic [3:0] CMD_STOP_ALL    = 4'd9;

	localparam logic [1:0] TYPE_EFFECT = 2'd0;
	localparam logic [1:0] TYPE_MUSIC  = 2'd1;
	localparam logic [1:0] TYPE_VOICE  = 2'd2;

	localparam logic [1:0] EV_ALLOC   = 2'd0;
	localparam logic [1:0] EV_VOLUME  = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_DONE    = 2'd3;

	typedef struct packed {
		logic [7:0]  flags;
		logic [9:0]  len;
		logic [10:0] pos;
		logic [6:0]  vol;
		logic [6:0]  pan;
		logic [6:0]  succ;
	} acfm_rec_t;

	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] addr;
		acfm_rec_t       data;
	} acfm_wr_t;

	localparam acfm_rec_t REC_CLEAR = '{flags: 8'h00, len: 10'd0, pos: 11'd0,
		vol: 7'd0, pan: 7'd0, succ: NO_SUCC};
	localparam acfm_rec_t REC_ALLOC = '{flags: 8'h00, len: 10'd0, pos: 11'd0,
		vol: VOL_FULL, pan: PAN_CENTER, succ: NO_SUCC};

	function automatic acfm_rec_t stop_rec(input acfm_rec_t r, input logic [9:0] mag);
		acfm_rec_t s;
		s = r;
		s.flags[F_WAIT] = 1'b0;
		s.flags[F_FADE_IN] = 1'b0;
		if (!r.flags[F_FADE_OUT]) begin
			s.flags[F_FADE_OUT] = 1'b1;
			s.len = mag;
			s.pos = '0;
		end
		return s;
	endfunction

endpackage

### rtl/core/audio_channel_fade_manager.sv
// Top level of the channel fade manager: sequencer, config register, output stage.
//
//  port group  | handshake                    | moves
//  ------------+------------------------------+------------------------------------------
//  in          | in_valid / in_ready          | one command per transfer
//  out         | out_valid / out_ready        | one event per transfer, last on the final
//  apb         | psel, penable, pwrite, pready| sound_enabled at byte address 0
//
// A command is taken only when the sequencer is idle. A single-channel command reads
// and updates its record (S_CRD, S_CUSE), for a stream handover also the previous one
// (S_PRD, S_PUSE); allocation scans one slot per cycle. A tick visits one channel per
// cycle when inactive; an active one runs S_TSEL, S_TRD, S_TUSE, S_TDIV for a ramp
// step's serial division, S_TEMIT, then S_SRD, S_SUSE if a waiting successor wakes;
// stop all adds one pass over the table first; the table memory's single read port
// and the shared divider set this pacing. Reset clears the sequencer, the active bits
// and the table's written bits at once. A held event stalls the sequencer until it is taken.
module audio_channel_fade_manager import acfm_pkg::*; #(
	parameter int NUM_CHANNELS      = NUM_CHANNELS_DEF,
	parameter int FIRST_MUSIC_SLOT  = FIRST_MUSIC_DEF,
	parameter int FIRST_EFFECT_SLOT = FIRST_EFFECT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// commands
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3:0]              command,
	input  logic [CH_W-1:0]         channel,
	input  logic [1:0]              sound_type,
	input  logic signed [10:0]      fade_ticks,
	input  logic [CH_W-1:0]         prev_channel,
	input  logic                    prev_valid,
	input  logic [6:0]              level,
	// events
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              event_kind,
	output logic [CH_W-1:0]         channel_out,
	output logic                    handle_valid,
	output logic                    start_stream,
	output logic [6:0]              volume_out,
	output logic [6:0]              pan_out,
	output logic                    last
);

	localparam int         IW   = $clog2(NUM_CHANNELS);
	localparam logic [6:0] N7   = 7'(NUM_CHANNELS);
	localparam logic [5:0] FMS6 = 6'(FIRST_MUSIC_SLOT);
	localparam logic [5:0] FES6 = 6'(FIRST_EFFECT_SLOT);
	localparam logic [IW-1:0] LAST_CH = IW'(NUM_CHANNELS - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_CRD, S_CUSE, S_PRD, S_PUSE,
		S_ASEL, S_ARD, S_AUSE,
		S_TSEL, S_TRD, S_TUSE, S_TDIV, S_TEMIT, S_SRD, S_SUSE,
		S_EFF, S_MSC, S_FIN
	} state_t;

	state_t              state_q;
	logic                enabled_q;
	logic [3:0]          cmd_q;
	logic [CH_W-1:0]     ch_q;
	logic [CH_W-1:0]     prev_q;
	logic                havep_q;
	logic                pos_fade_q;
	logic [9:0]          mag_q;
	logic [6:0]          level_q;
	logic [IW-1:0]       i_q;
	logic [5:0]          idx_q;
	logic [5:0]          hi_q;
	logic [6:0]          cnt_q;
	logic [5:0]          cursor_q;
	logic [CH_W-1:0]     rd_addr_q;
	logic [NUM_CHANNELS-1:0] active_q;
	logic [5:0]          evt_cnt_q;
	acfm_rec_t           rec_q;
	logic [6:0]          nv_q;
	logic                ev_en_q;
	logic [1:0]          ev_kind_q;
	logic                ev_start_q;
	logic [6:0]          ev_pan_q;
	logic                ev_scale_q;
	logic                rel_q;
	logic                supd_q;
	logic [6:0]          succ_q;
	logic [1:0]          fin_kind_q;
	logic [CH_W-1:0]     fin_ch_q;
	logic                fin_hv_q;
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic [CH_W-1:0]     och_q;
	logic                hv_q;
	logic                start_q;
	logic [6:0]          vol_q;
	logic [6:0]          pan_q;
	logic                last_q;

	acfm_rec_t           r;
	acfm_wr_t            wr;
	logic                div_start;
	logic                div_done;
	logic [DVD_W-1:0]    div_quot;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_SOUND_ENABLED) begin
			enabled_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SOUND_ENABLED) ? {31'd0, enabled_q} : 32'd0;

	// ---------------------------------------------------------------- input decode
	logic [10:0] raw_neg;
	logic [10:0] mag11;
	logic [9:0]  in_mag;
	logic        in_posfade;
	logic        in_chok;
	logic        in_havep;

	always_comb begin
		raw_neg    = ~fade_ticks + 11'd1;
		mag11      = fade_ticks[10] ? raw_neg : fade_ticks;
		in_mag     = mag11[10] ? MAG_MAX : mag11[9:0];
		in_posfade = !fade_ticks[10] && (fade_ticks != '0);
		in_chok    = {1'b0, channel} < N7;
		in_havep   = prev_valid && ({1'b0, prev_channel} < N7);
	end

	logic can_emit;
	logic ev_ok;
	assign can_emit = !out_valid_q || out_ready;
	assign ev_ok    = evt_cnt_q < 6'(EVENT_CAP);

	// ---------------------------------------------------------------- single command
	acfm_rec_t   c_rec;
	logic        c_emit;
	logic        c_rel;
	logic [1:0]  c_kind;
	logic [6:0]  c_vol;
	logic [6:0]  c_pan;
	logic        c_go;

	always_comb begin
		c_rec  = r;
		c_emit = 1'b0;
		c_rel  = 1'b0;
		c_kind = EV_VOLUME;
		c_vol  = r.vol;
		c_pan  = r.pan;
		unique case (cmd_q)
			CMD_PLAY_STREAM: begin
				c_rec.len = mag_q;
				c_rec.pos = '0;
				c_rec.flags[F_STREAMED] = 1'b1;
				if (pos_fade_q && havep_q) begin
					c_rec.flags[F_WAIT] = 1'b1;
				end else begin
					c_rec.flags[F_FADE_IN] = 1'b1;
				end
			end
			CMD_PLAY_MEMORY: begin
				c_rec.flags[F_MEMORY] = 1'b1;
				c_rec.flags[F_DONE]   = 1'b0;
				c_emit = 1'b1;
			end
			CMD_STOP: begin
				c_rec = stop_rec(r, mag_q);
			end
			CMD_SET_VOLUME: begin
				if (r.vol != level_q) begin
					c_rec.vol = level_q;
					c_vol     = level_q;
					if (r.flags[F_STREAMED]) begin
						c_emit = 1'b1;
						c_pan  = PAN_CENTER;
					end else if (r.flags[F_MEMORY]) begin
						c_emit = 1'b1;
					end
				end
			end
			CMD_SET_PAN: begin
				if (r.pan != level_q) begin
					c_rec.pan = level_q;
					c_pan     = level_q;
					c_emit    = !r.flags[F_STREAMED] && r.flags[F_MEMORY];
				end
			end
			CMD_PLAY_DONE: begin
				c_rec.flags[F_DONE] = 1'b1;
			end
			CMD_DESTROY: begin
				if (active_q[ch_q[IW-1:0]]) begin
					c_rec  = stop_rec(r, 10'd0);
					c_rel  = 1'b1;
					c_emit = 1'b1;
					c_kind = EV_RELEASE;
					c_vol  = '0;
					c_pan  = '0;
				end
			end
			default: ;
		endcase
		c_go = !c_emit || !ev_ok || can_emit;
	end

	// previous channel handed over to fade out
	acfm_rec_t p_rec;
	always_comb begin
		p_rec = r;
		p_rec.flags[F_FADE_IN]  = 1'b0;
		p_rec.flags[F_WAIT]     = 1'b0;
		p_rec.flags[F_FADE_OUT] = 1'b1;
		p_rec.len  = mag_q;
		p_rec.pos  = '0;
		p_rec.succ = {1'b0, ch_q};
	end

	// successor wakes into a fade in
	acfm_rec_t s_rec;
	always_comb begin
		s_rec = r;
		s_rec.flags[F_WAIT]    = 1'b0;
		s_rec.flags[F_FADE_IN] = 1'b1;
	end

	// ---------------------------------------------------------------- tick step
	acfm_rec_t        t_rec;
	logic             t_div;
	logic [DVD_W-1:0] t_dividend;
	logic [6:0]       t_nv;
	logic             t_emit;
	logic [1:0]       t_kind;
	logic             t_start;
	logic [6:0]       t_pan;
	logic             t_scale;
	logic             t_rel;
	logic             t_supd;
	logic [10:0]      pos1;
	logic             in_len;
	logic [9:0]       remain;
	logic [6:0]       i7;

	always_comb begin
		t_rec      = r;
		t_div      = 1'b0;
		t_dividend = '0;
		t_nv       = '0;
		t_emit     = 1'b0;
		t_kind     = EV_VOLUME;
		t_start    = 1'b0;
		t_pan      = PAN_CENTER;
		t_scale    = 1'b0;
		t_rel      = 1'b0;
		t_supd     = 1'b0;
		pos1       = r.pos + 11'd1;
		in_len     = pos1 <= {1'b0, r.len};
		remain     = r.len - pos1[9:0];
		i7         = 7'(i_q);
		priority if (r.flags[F_WAIT]) begin
			t_rec = r;
		end else if (r.flags[F_FADE_OUT]) begin
			t_rec.pos = pos1;
			if (in_len) begin
				t_div      = 1'b1;
				t_dividend = {10'd0, r.vol} * {7'd0, remain};
			end else begin
				t_rec.flags[F_FADE_OUT] = 1'b0;
				if (r.succ < N7) begin
					if (r.succ == i7) begin
						t_rec.flags[F_WAIT]    = 1'b0;
						t_rec.flags[F_FADE_IN] = 1'b1;
					end else begin
						t_supd = 1'b1;
					end
				end
			end
			t_rec.flags[F_DESTROY] = 1'b1;
			if (r.flags[F_STREAMED]) begin
				t_emit = 1'b1;
			end else if (r.flags[F_MEMORY]) begin
				t_emit  = 1'b1;
				t_pan   = r.pan;
				t_scale = 1'b1;
			end
		end else if (r.flags[F_FADE_IN]) begin
			t_start   = (r.pos == '0);
			t_rec.pos = pos1;
			t_nv      = r.vol;
			if (in_len) begin
				t_div      = 1'b1;
				t_dividend = {7'd0, pos1[9:0]} * {10'd0, r.vol};
			end else begin
				t_rec.flags[F_FADE_IN] = 1'b0;
			end
			t_emit = r.flags[F_STREAMED] || r.flags[F_MEMORY] || t_start;
		end else begin
			if (r.flags[F_MEMORY] && r.flags[F_DONE]) begin
				t_rec.flags[F_DESTROY] = 1'b1;
			end
			if (t_rec.flags[F_DESTROY]) begin
				t_rec  = stop_rec(t_rec, 10'd0);
				t_rel  = 1'b1;
				t_emit = 1'b1;
				t_kind = EV_RELEASE;
				t_pan  = '0;
			end
		end
	end

	assign div_start = (state_q == S_TUSE) && t_div;

	// memory sounds scale the ramp by their own volume over 128
	logic [13:0] scaled;
	logic [6:0]  t_out_vol;
	logic        t_go;
	assign scaled    = nv_q * rec_q.vol;
	assign t_out_vol = ev_scale_q ? scaled[13:7] : nv_q;
	assign t_go      = !ev_en_q || !ev_ok || can_emit;

	// an event register load this cycle; keeps out_valid_q set on a same-cycle transfer
	logic ev_load;
	assign ev_load = ((state_q == S_CUSE) && c_go && c_emit && ev_ok)
		|| ((state_q == S_TEMIT) && t_go && ev_en_q && ev_ok)
		|| ((state_q == S_FIN) && can_emit);

	// ---------------------------------------------------------------- allocation scan
	logic [6:0] cur_inc;
	logic       eff_found;
	logic       msc_ok;
	logic       msc_found;
	assign cur_inc   = {1'b0, cursor_q} + 7'd1;
	assign eff_found = ({1'b0, cursor_q} < N7) && !active_q[cursor_q[IW-1:0]];
	assign msc_ok    = (idx_q < hi_q) && ({1'b0, idx_q} < N7);
	assign msc_found = msc_ok && !active_q[idx_q[IW-1:0]];

	// ---------------------------------------------------------------- table write port
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = CH_W'(i_q);
		wr.data = rec_q;
		unique case (state_q)
			S_CUSE: begin
				wr.en   = c_go;
				wr.addr = ch_q;
				wr.data = c_rec;
			end
			S_PUSE: begin
				wr.en   = 1'b1;
				wr.addr = prev_q;
				wr.data = p_rec;
			end
			S_AUSE: begin
				wr.en   = 1'b1;
				wr.data = stop_rec(r, mag_q);
			end
			S_TEMIT: begin
				wr.en = t_go;
			end
			S_SUSE: begin
				wr.en   = 1'b1;
				wr.addr = succ_q[CH_W-1:0];
				wr.data = s_rec;
			end
			S_EFF: begin
				wr.en   = (cnt_q != N7) && eff_found;
				wr.addr = cursor_q;
				wr.data = REC_ALLOC;
			end
			S_MSC: begin
				wr.en   = msc_found;
				wr.addr = idx_q;
				wr.data = REC_ALLOC;
			end
			default: ;
		endcase
	end

	acfm_table #(.DEPTH(NUM_CHANNELS)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr_q),
		.rd_data (r)
	);

	acfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_dividend),
		.divisor  (r.len),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			ch_q        <= '0;
			prev_q      <= '0;
			havep_q     <= 1'b0;
			pos_fade_q  <= 1'b0;
			mag_q       <= '0;
			level_q     <= '0;
			i_q         <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			cnt_q       <= '0;
			cursor_q    <= FES6;
			rd_addr_q   <= '0;
			active_q    <= '0;
			evt_cnt_q   <= '0;
			rec_q       <= REC_CLEAR;
			nv_q        <= '0;
			ev_en_q     <= 1'b0;
			ev_kind_q   <= EV_VOLUME;
			ev_start_q  <= 1'b0;
			ev_pan_q    <= '0;
			ev_scale_q  <= 1'b0;
			rel_q       <= 1'b0;
			supd_q      <= 1'b0;
			succ_q      <= NO_SUCC;
			fin_kind_q  <= EV_DONE;
			fin_ch_q    <= '0;
			fin_hv_q    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= EV_DONE;
			och_q       <= '0;
			hv_q        <= 1'b0;
			start_q     <= 1'b0;
			vol_q       <= '0;
			pan_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !ev_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= command;
						ch_q       <= channel;
						prev_q     <= prev_channel;
						havep_q    <= in_havep;
						pos_fade_q <= in_posfade;
						mag_q      <= in_mag;
						level_q    <= level;
						evt_cnt_q  <= '0;
						i_q        <= '0;
						fin_kind_q <= (command == CMD_ALLOC) ? EV_ALLOC : EV_DONE;
						fin_ch_q   <= '0;
						fin_hv_q   <= 1'b0;
						if (command == CMD_ALLOC) begin
							if (!enabled_q) begin
								state_q <= S_FIN;
							end else if (sound_type == TYPE_EFFECT) begin
								cnt_q   <= '0;
								state_q <= S_EFF;
							end else if (sound_type == TYPE_MUSIC) begin
								idx_q   <= FMS6;
								hi_q    <= FES6;
								state_q <= S_MSC;
							end else if (sound_type == TYPE_VOICE) begin
								idx_q   <= '0;
								hi_q    <= FMS6;
								state_q <= S_MSC;
							end else begin
								state_q <= S_FIN;
							end
						end else if (!enabled_q) begin
							state_q <= S_FIN;
						end else if (command == CMD_TICK) begin
							state_q <= S_TSEL;
						end else if (command == CMD_STOP_ALL) begin
							state_q <= S_ASEL;
						end else if (in_chok && command >= CMD_PLAY_STREAM
							&& command <= CMD_DESTROY) begin
							rd_addr_q <= channel;
							state_q   <= S_CRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_CRD: begin
					state_q <= S_CUSE;
				end
				S_CUSE: begin
					if (c_go) begin
						if (c_rel) begin
							active_q[ch_q[IW-1:0]] <= 1'b0;
						end
						if (c_emit && ev_ok) begin
							out_valid_q <= 1'b1;
							kind_q      <= c_kind;
							och_q       <= ch_q;
							hv_q        <= 1'b0;
							start_q     <= 1'b0;
							vol_q       <= c_vol;
							pan_q       <= c_pan;
							last_q      <= 1'b0;
							evt_cnt_q   <= evt_cnt_q + 6'd1;
						end
						if (cmd_q == CMD_PLAY_STREAM && havep_q) begin
							rd_addr_q <= prev_q;
							state_q   <= S_PRD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_PRD: begin
					state_q <= S_PUSE;
				end
				S_PUSE: begin
					state_q <= S_FIN;
				end
				S_ASEL: begin
					if (active_q[i_q]) begin
						rd_addr_q <= CH_W'(i_q);
						state_q   <= S_ARD;
					end else if (i_q == LAST_CH) begin
						cursor_q <= FES6;
						i_q      <= '0;
						state_q  <= S_TSEL;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				S_ARD: begin
					state_q <= S_AUSE;
				end
				S_AUSE: begin
					if (i_q == LAST_CH) begin
						cursor_q <= FES6;
						i_q      <= '0;
						state_q  <= S_TSEL;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_ASEL;
					end
				end
				S_TSEL: begin
					if (active_q[i_q]) begin
						rd_addr_q <= CH_W'(i_q);
						state_q   <= S_TRD;
					end else if (i_q == LAST_CH) begin
						state_q <= S_FIN;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				S_TRD: begin
					state_q <= S_TUSE;
				end
				S_TUSE: begin
					rec_q      <= t_rec;
					nv_q       <= t_nv;
					ev_en_q    <= t_emit;
					ev_kind_q  <= t_kind;
					ev_start_q <= t_start;
					ev_pan_q   <= t_pan;
					ev_scale_q <= t_scale;
					rel_q      <= t_rel;
					supd_q     <= t_supd;
					succ_q     <= r.succ;
					state_q    <= t_div ? S_TDIV : S_TEMIT;
				end
				S_TDIV: begin
					if (div_done) begin
						nv_q    <= div_quot[6:0];
						state_q <= S_TEMIT;
					end
				end
				S_TEMIT: begin
					if (t_go) begin
						if (rel_q) begin
							active_q[i_q] <= 1'b0;
						end
						if (ev_en_q && ev_ok) begin
							out_valid_q <= 1'b1;
							kind_q      <= ev_kind_q;
							och_q       <= CH_W'(i_q);
							hv_q        <= 1'b0;
							start_q     <= ev_start_q;
							vol_q       <= t_out_vol;
							pan_q       <= ev_pan_q;
							last_q      <= 1'b0;
							evt_cnt_q   <= evt_cnt_q + 6'd1;
						end
						if (supd_q) begin
							rd_addr_q <= succ_q[CH_W-1:0];
							state_q   <= S_SRD;
						end else if (i_q == LAST_CH) begin
							state_q <= S_FIN;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_TSEL;
						end
					end
				end
				S_SRD: begin
					state_q <= S_SUSE;
				end
				S_SUSE: begin
					if (i_q == LAST_CH) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_TSEL;
					end
				end
				S_EFF: begin
					if (cnt_q == N7) begin
						state_q <= S_FIN;
					end else if (eff_found) begin
						active_q[cursor_q[IW-1:0]] <= 1'b1;
						fin_ch_q <= cursor_q;
						fin_hv_q <= 1'b1;
						state_q  <= S_FIN;
					end else begin
						cursor_q <= (cur_inc >= N7) ? FES6 : cur_inc[5:0];
						cnt_q    <= cnt_q + 7'd1;
					end
				end
				S_MSC: begin
					if (msc_found) begin
						active_q[idx_q[IW-1:0]] <= 1'b1;
						fin_ch_q <= idx_q;
						fin_hv_q <= 1'b1;
						state_q  <= S_FIN;
					end else if (msc_ok) begin
						idx_q <= idx_q + 6'd1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						kind_q      <= fin_kind_q;
						och_q       <= fin_ch_q;
						hv_q        <= fin_hv_q;
						start_q     <= 1'b0;
						vol_q       <= '0;
						pan_q       <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign channel_out  = och_q;
	assign handle_valid = hv_q;
	assign start_stream = start_q;
	assign volume_out   = vol_q;
	assign pan_out      = pan_q;
	assign last         = last_q;

	// ---------------------------------------------------------------- checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer stayed idle after taking a command");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_TDIV))
		else $error("divider finished outside the ramp wait");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr.en)
		else $error("table written while idle");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (kind_q == EV_DONE || kind_q == EV_ALLOC))
		else $error("final event is not a reply or step done");

endmodule

### rtl/core/acfm_div.sv
// Restoring serial divider, one quotient bit per cycle.
module acfm_div import acfm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			dvs_q  <= divisor;
			quo_q  <= dividend;
			cnt_q  <= 5'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q  <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q  <= {quo_q[DVD_W-2:0], qbit};
			cnt_q  <= cnt_q - 5'd1;
			done_q <= (cnt_q == 5'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/acfm_table.sv
// Channel record memory with per-entry written bits.
module acfm_table import acfm_pkg::*; #(
	parameter int DEPTH = NUM_CHANNELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  acfm_wr_t        wr,
	input  logic [CH_W-1:0] rd_addr,
	output acfm_rec_t       rd_data
);

	localparam int AW = $clog2(DEPTH);

	acfm_rec_t        mem [DEPTH];
	acfm_rec_t        rd_q;
	logic             rd_wr_q;
	logic [DEPTH-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rd_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_wr_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			rd_wr_q <= written_q[rd_addr[AW-1:0]];
		end
	end

	// never-written entries read as the cleared record
	assign rd_data = rd_wr_q ? rd_q : REC_CLEAR;

endmodule

### sim/acfm_checker.sv
// Scoreboard for the channel fade manager: tracks the channel table, predicts events, compares.
module acfm_checker import acfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [3:0]        command,
	input  logic [CH_W-1:0]   channel,
	input  logic [1:0]        sound_type,
	input  logic signed [10:0] fade_ticks,
	input  logic [CH_W-1:0]   prev_channel,
	input  logic              prev_valid,
	input  logic [6:0]        level,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [1:0]        event_kind,
	input  logic [CH_W-1:0]   channel_out,
	input  logic              handle_valid,
	input  logic              start_stream,
	input  logic [6:0]        volume_out,
	input  logic [6:0]        pan_out,
	input  logic              last,
	output int                fail_count,
	output int                pending,
	output int                items_seen,
	output int                events_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = NUM_CHANNELS_DEF;
	localparam int FIRST_MUSIC = FIRST_MUSIC_DEF;
	localparam int FIRST_EFFECT = FIRST_EFFECT_DEF;

	typedef struct packed {
		logic [1:0]      kind;
		logic [CH_W-1:0] ch;
		logic            hv;
		logic            ss;
		logic [6:0]      vol;
		logic [6:0]      pan;
		logic            lst;
	} chan_event_t;

	logic        enabled;
	logic        active [NCH];
	logic [7:0]  flags [NCH];
	int unsigned fade_len [NCH];
	int unsigned fade_pos [NCH];
	int unsigned volume [NCH];
	int unsigned pan [NCH];
	int unsigned successor [NCH];
	int unsigned effect_cursor;
	int          step_events;
	chan_event_t expected_events [$];

	task automatic clear_table();
		enabled = 1'b1;
		for (int i = 0; i < NCH; i++) begin
			active[i] = 1'b0;
			flags[i] = '0;
			fade_len[i] = 0;
			fade_pos[i] = 0;
			volume[i] = 0;
			pan[i] = 0;
			successor[i] = NO_SUCC;
		end
		effect_cursor = FIRST_EFFECT;
		expected_events.delete();
	endtask

	task automatic queue_event(input logic [1:0] kind, input int unsigned ch, input logic hv,
			input logic ss, input int unsigned v, input int unsigned p, input logic lst);
		chan_event_t e;
		e.kind = kind;
		e.ch = ch[CH_W-1:0];
		e.hv = hv;
		e.ss = ss;
		e.vol = v[6:0];
		e.pan = p[6:0];
		e.lst = lst;
		expected_events.push_back(e);
	endtask

	// per-channel events are capped per step; the closing event is not
	task automatic channel_event(input logic [1:0] kind, input int unsigned ch, input logic ss,
			input int unsigned v, input int unsigned p);
		if (step_events < EVENT_CAP) begin
			queue_event(kind, ch, 1'b0, ss, v, p, 1'b0);
			step_events++;
		end
	endtask

	task automatic open_channel(input int unsigned i);
		flags[i] = '0;
		fade_len[i] = 0;
		fade_pos[i] = 0;
		volume[i] = VOL_FULL;
		pan[i] = PAN_CENTER;
		successor[i] = NO_SUCC;
		active[i] = 1'b1;
	endtask

	task automatic begin_fade_out(input int unsigned i, input int unsigned mag);
		flags[i][F_WAIT] = 1'b0;
		flags[i][F_FADE_IN] = 1'b0;
		if (!flags[i][F_FADE_OUT]) begin
			flags[i][F_FADE_OUT] = 1'b1;
			fade_len[i] = mag;
			fade_pos[i] = 0;
		end
	endtask

	task automatic find_slot(input logic [1:0] kind, output int slot);
		int lo;
		int hi;
		slot = -1;
		if (kind == TYPE_EFFECT) begin
			for (int n = 0; n < NCH; n++) begin
				if (effect_cursor < NCH && !active[effect_cursor]) begin
					open_channel(effect_cursor);
					slot = effect_cursor;
					return;
				end
				effect_cursor++;
				if (effect_cursor >= NCH)
					effect_cursor = FIRST_EFFECT;
			end
		end else if (kind == TYPE_MUSIC || kind == TYPE_VOICE) begin
			lo = (kind == TYPE_MUSIC) ? FIRST_MUSIC : 0;
			hi = (kind == TYPE_MUSIC) ? FIRST_EFFECT : FIRST_MUSIC;
			for (int i = lo; i < hi && i < NCH; i++) begin
				if (!active[i]) begin
					open_channel(i);
					slot = i;
					return;
				end
			end
		end
	endtask

	task automatic run_tick();
		logic [7:0]  f;
		int unsigned len;
		int unsigned v;
		int unsigned nv;
		int unsigned s;
		logic        starting;
		for (int i = 0; i < NCH; i++) begin
			f = flags[i];
			len = fade_len[i];
			v = volume[i];
			if (!active[i] || f[F_WAIT])
				continue;
			if (f[F_FADE_OUT]) begin
				fade_pos[i]++;
				if (fade_pos[i] <= len) begin
					nv = v * (len - fade_pos[i]) / len;
				end else begin
					s = successor[i];
					flags[i][F_FADE_OUT] = 1'b0;
					if (s < NCH) begin
						flags[s][F_WAIT] = 1'b0;
						flags[s][F_FADE_IN] = 1'b1;
					end
					nv = 0;
				end
				if (f[F_STREAMED])
					channel_event(EV_VOLUME, i, 1'b0, nv, PAN_CENTER);
				else if (f[F_MEMORY])
					channel_event(EV_VOLUME, i, 1'b0, nv * v / 128, pan[i]);
				flags[i][F_DESTROY] = 1'b1;
			end else if (f[F_FADE_IN]) begin
				starting = (fade_pos[i] == 0);
				fade_pos[i]++;
				nv = v;
				if (fade_pos[i] <= len)
					nv = fade_pos[i] * v / len;
				else
					flags[i][F_FADE_IN] = 1'b0;
				if (f[F_STREAMED] || f[F_MEMORY] || starting)
					channel_event(EV_VOLUME, i, starting, nv, PAN_CENTER);
			end else begin
				if (f[F_MEMORY] && f[F_DONE])
					flags[i][F_DESTROY] = 1'b1;
				if (flags[i][F_DESTROY]) begin
					begin_fade_out(i, 0);
					active[i] = 1'b0;
					channel_event(EV_RELEASE, i, 1'b0, 0, 0);
				end
			end
		end
	endtask

	task automatic predict_command(input logic [3:0] cmd, input int unsigned ch,
			input logic [1:0] kind, input logic [10:0] raw, input int unsigned prev,
			input logic pv, input int unsigned lvl);
		int unsigned mag;
		logic        pos_fade;
		logic        chok;
		logic        havep;
		int          slot;
		mag = raw[10] ? 2048 - raw : raw;
		if (mag > MAG_MAX)
			mag = MAG_MAX;
		pos_fade = !raw[10] && raw != 0;
		chok = ch < NCH;
		step_events = 0;
		if (cmd == CMD_ALLOC) begin
			slot = -1;
			if (enabled)
				find_slot(kind, slot);
			queue_event(EV_ALLOC, slot >= 0 ? slot : 0, slot >= 0, 1'b0, 0, 0, 1'b1);
			return;
		end
		if (enabled) begin
			case (cmd)
				CMD_PLAY_STREAM: if (chok) begin
					havep = pv && prev < NCH;
					fade_len[ch] = mag;
					fade_pos[ch] = 0;
					flags[ch][F_STREAMED] = 1'b1;
					if (pos_fade && havep)
						flags[ch][F_WAIT] = 1'b1;
					else
						flags[ch][F_FADE_IN] = 1'b1;
					if (havep) begin
						flags[prev][F_FADE_IN] = 1'b0;
						flags[prev][F_WAIT] = 1'b0;
						flags[prev][F_FADE_OUT] = 1'b1;
						fade_len[prev] = mag;
						fade_pos[prev] = 0;
						successor[prev] = ch;
					end
				end
				CMD_PLAY_MEMORY: if (chok) begin
					flags[ch][F_MEMORY] = 1'b1;
					flags[ch][F_DONE] = 1'b0;
					channel_event(EV_VOLUME, ch, 1'b0, volume[ch], pan[ch]);
				end
				CMD_STOP: if (chok)
					begin_fade_out(ch, mag);
				CMD_SET_VOLUME: if (chok && volume[ch] != lvl) begin
					volume[ch] = lvl;
					if (flags[ch][F_STREAMED])
						channel_event(EV_VOLUME, ch, 1'b0, lvl, PAN_CENTER);
					else if (flags[ch][F_MEMORY])
						channel_event(EV_VOLUME, ch, 1'b0, lvl, pan[ch]);
				end
				CMD_SET_PAN: if (chok && pan[ch] != lvl) begin
					pan[ch] = lvl;
					if (!flags[ch][F_STREAMED] && flags[ch][F_MEMORY])
						channel_event(EV_VOLUME, ch, 1'b0, volume[ch], lvl);
				end
				CMD_PLAY_DONE: if (chok)
					flags[ch][F_DONE] = 1'b1;
				CMD_DESTROY: if (chok && active[ch]) begin
					begin_fade_out(ch, 0);
					active[ch] = 1'b0;
					channel_event(EV_RELEASE, ch, 1'b0, 0, 0);
				end
				CMD_TICK:
					run_tick();
				CMD_STOP_ALL: begin
					for (int i = 0; i < NCH; i++)
						if (active[i])
							begin_fade_out(i, mag);
					effect_cursor = FIRST_EFFECT;
					run_tick();
				end
				default: ;
			endcase
		end
		queue_event(EV_DONE, 0, 1'b0, 1'b0, 0, 0, 1'b1);
	endtask

	task automatic check_event();
		chan_event_t want;
		chan_event_t got;
		got = '{kind: event_kind, ch: channel_out, hv: handle_valid, ss: start_stream,
			vol: volume_out, pan: pan_out, lst: last};
		events_seen++;
		if (expected_events.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("chk: unexpected event %p", got);
			return;
		end
		want = expected_events.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("chk: event mismatch, expected %p, got %p", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			fail_count = 0;
			items_seen = 0;
			events_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'(REG_SOUND_ENABLED))
				enabled = pwdata[0];
			if (in_valid && in_ready) begin
				items_seen++;
				predict_command(command, channel, sound_type, fade_ticks, prev_channel,
					prev_valid, level);
			end
			if (out_valid && out_ready)
				check_event();
		end
		pending = expected_events.size();
	end

endmodule

### sim/audio_channel_fade_manager_test.sv
// Testbench top for the channel fade manager: clock, reset, stimulus and verdict.
module audio_channel_fade_manager_test;
	import acfm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = NUM_CHANNELS_DEF;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [3:0]        command;
	logic [CH_W-1:0]   channel;
	logic [1:0]        sound_type;
	logic signed [10:0] fade_ticks;
	logic [CH_W-1:0]   prev_channel;
	logic              prev_valid;
	logic [6:0]        level;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        event_kind;
	logic [CH_W-1:0]   channel_out;
	logic              handle_valid;
	logic              start_stream;
	logic [6:0]        volume_out;
	logic [6:0]        pan_out;
	logic              last;

	int fail_count;
	int pending;
	int items_seen;
	int events_seen;

	// idle rates in percent, changed per phase
	int send_idle_pct;
	int recv_idle_pct;

	audio_channel_fade_manager dut (.*);

	acfm_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// receiver stalls; one assignment per edge, so no glitch on out_ready
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// one command transfer; optional idle gap first, valid held until accepted
	task automatic send_command(input logic [3:0] cmd, input logic [CH_W-1:0] ch,
			input logic [1:0] kind, input logic signed [10:0] ft, input logic [CH_W-1:0] prev,
			input logic pv, input logic [6:0] lvl);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		command <= cmd;
		channel <= ch;
		sound_type <= kind;
		fade_ticks <= ft;
		prev_channel <= prev;
		prev_valid <= pv;
		level <= lvl;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// let all expected events drain, then give the sequencer time to settle
	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (50) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; register lands at the access edge
	task automatic write_enable(input logic value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(REG_SOUND_ENABLED);
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// channels cluster low so commands mostly hit allocated slots
	function automatic logic [CH_W-1:0] pick_channel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CH_W'($urandom_range(0, 15));
		if (r < 95)
			return CH_W'($urandom_range(0, NCH - 1));
		return CH_W'($urandom_range(NCH, 63));
	endfunction

	// short fades let ramps finish; now and then a raw 11-bit value
	function automatic logic signed [10:0] pick_fade();
		logic signed [10:0] ft;
		if ($urandom_range(0, 4) == 0)
			return 11'($urandom_range(0, 2047));
		ft = 11'($urandom_range(0, 6));
		return $urandom_range(0, 1) ? -ft : ft;
	endfunction

	task automatic random_command();
		int         r;
		logic [3:0] cmd;
		logic [1:0] kind;
		r = $urandom_range(0, 99);
		kind = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		if (r < 18)       cmd = CMD_ALLOC;
		else if (r < 40)  cmd = CMD_TICK;
		else if (r < 50)  cmd = CMD_PLAY_STREAM;
		else if (r < 58)  cmd = CMD_PLAY_MEMORY;
		else if (r < 65)  cmd = CMD_STOP;
		else if (r < 72)  cmd = CMD_SET_VOLUME;
		else if (r < 78)  cmd = CMD_SET_PAN;
		else if (r < 84)  cmd = CMD_PLAY_DONE;
		else if (r < 90)  cmd = CMD_DESTROY;
		else if (r < 93)  cmd = CMD_STOP_ALL;
		else if (r < 96)  cmd = 4'($urandom_range(10, 15));
		else              cmd = 4'($urandom_range(0, 15));
		send_command(cmd, pick_channel(), kind, pick_fade(),
			($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : pick_channel(),
			1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
	endtask

	task automatic random_run(input int count);
		repeat (count)
			random_command();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = '0;
		channel = '0;
		sound_type = '0;
		fade_ticks = '0;
		prev_channel = '0;
		prev_valid = 1'b0;
		level = '0;
		send_idle_pct = 37;
		recv_idle_pct = 57;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_enable(1'b1);

		// directed: voice range fills after two, music, effects, unknown type
		send_command(CMD_ALLOC, 0, TYPE_VOICE, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, TYPE_VOICE, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, TYPE_VOICE, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, TYPE_MUSIC, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, TYPE_EFFECT, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, TYPE_EFFECT, 0, 0, 0, 0);
		send_command(CMD_ALLOC, 0, 2'd3, 0, 0, 0, 0);
		// memory sound on a voice slot, level extremes, pan change
		send_command(CMD_PLAY_MEMORY, 0, 0, 0, 0, 0, 0);
		send_command(CMD_SET_VOLUME, 0, 0, 0, 0, 0, 7'd0);
		send_command(CMD_SET_VOLUME, 0, 0, 0, 0, 0, 7'd127);
		send_command(CMD_SET_PAN, 0, 0, 0, 0, 0, 7'd127);
		// stream on the other voice slot handing over from the music slot, positive fade waits
		send_command(CMD_PLAY_STREAM, 1, 0, 11'sd3, 6'd2, 1'b1, 0);
		send_command(CMD_PLAY_STREAM, 2, 0, -11'sd2, 6'd63, 1'b1, 0);
		send_command(CMD_TICK, 0, 0, 0, 0, 0, 0);
		send_command(CMD_TICK, 0, 0, 0, 0, 0, 0);
		// playback done on the memory sound, then a tick releases it
		send_command(CMD_PLAY_DONE, 0, 0, 0, 0, 0, 0);
		send_command(CMD_TICK, 0, 0, 0, 0, 0, 0);
		// most negative fades, out-of-range channel, unknown code
		send_command(CMD_STOP, 6, 0, -11'sd1023, 0, 0, 0);
		send_command(CMD_STOP, 63, 0, -11'sd1024, 0, 0, 7'd127);
		send_command(CMD_SET_VOLUME, 63, 3, 11'sd1023, 6'd63, 1'b1, 7'd127);
		send_command(4'd15, 63, 3, -11'sd1, 6'd63, 1'b1, 7'd127);
		send_command(CMD_DESTROY, 7, 0, 0, 0, 0, 0);
		send_command(CMD_DESTROY, 7, 0, 0, 0, 0, 0);
		send_command(CMD_STOP_ALL, 0, 0, 11'sd1, 0, 0, 0);
		send_command(CMD_TICK, 0, 0, 0, 0, 0, 0);
		drain();

		// receiver idles more than the sender
		random_run(75);

		// with sound off every other command only reports done, allocation finds nothing
		write_enable(1'b0);
		send_idle_pct = 57;
		recv_idle_pct = 37;
		random_run(12);
		write_enable(1'b1);

		// sender idles more than the receiver
		random_run(75);

		// back to back in both directions
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(70);

		$display("tb: %0d commands transferred, %0d events checked", items_seen, events_seen);
		$display("tb: covered allocation, streams, memory sounds, fades, sound off phase");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule

### files.f
rtl/core/acfm_pkg.sv
rtl/core/acfm_div.sv
rtl/core/acfm_table.sv
rtl/core/audio_channel_fade_manager.sv
sim/acfm_checker.sv
sim/audio_channel_fade_manager_test.sv
